@@ rtl/susk_pkg.sv @@
package susk_pkg;

    localparam int KeyWidth = 32;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_SEARCH = 2'd1,
        OP_POP    = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        STAT_OK       = 3'd0,
        STAT_DUP      = 3'd1,
        STAT_FULL     = 3'd2,
        STAT_NOTFOUND = 3'd3,
        STAT_EMPTY    = 3'd4
    } status_t;

    typedef enum logic {
        MODE_PLACE = 1'b0,
        MODE_PROBE = 1'b1
    } mode_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_WALK = 1'b1
    } state_t;

    // Token handed from one cell to the next
    typedef struct packed {
        logic                tok;
        mode_t               mode;
        logic                carry;
        logic                hit;
        logic [KeyWidth-1:0] key;
    } lnk_t;

endpackage

@@ rtl/susk_cell.sv @@
module susk_cell (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  susk_pkg::lnk_t                lnk_in,
    input  logic                          occ,
    input  logic                          pop_shift,
    input  logic [susk_pkg::KeyWidth-1:0] next_key,
    output susk_pkg::lnk_t                lnk_out,
    output logic [susk_pkg::KeyWidth-1:0] key_out
);
    import susk_pkg::*;

    logic [KeyWidth-1:0] key_reg;
    logic [KeyWidth-1:0] key_next;
    lnk_t                lnk_reg;
    lnk_t                lnk_next;

    always_comb begin
        lnk_next = lnk_in;
        key_next = key_reg;
        if (pop_shift) begin
            key_next = next_key;
        end
        if (lnk_in.tok && lnk_in.carry) begin
            if (!occ) begin
                // first free slot: stop carrying; in place mode the key settles here
                lnk_next.carry = 1'b0;
                if (lnk_in.mode == MODE_PLACE) begin
                    key_next = lnk_in.key;
                end
            end else if (key_reg == lnk_in.key) begin
                lnk_next.carry = 1'b0;
                lnk_next.hit   = 1'b1;
            end else if (key_reg > lnk_in.key) begin
                if (lnk_in.mode == MODE_PLACE) begin
                    // swap: keep the smaller key, push ours onward
                    key_next     = lnk_in.key;
                    lnk_next.key = key_reg;
                end else begin
                    lnk_next.carry = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        key_reg <= key_next;
        if (!aresetn) begin
            lnk_reg.tok <= 1'b0;
        end else begin
            lnk_reg <= lnk_next;
        end
    end

    assign lnk_out = lnk_reg;
    assign key_out = key_reg;

endmodule

@@ rtl/sorted_unique_key_set_core.sv @@
// Sorted unique key set.
// Holds up to DEPTH distinct 32-bit keys in ascending order in a row of cells.
// Input channel s_*: s_tuser carries the opcode (insert, search, pop, clear),
// s_tdata the key. Result channel m_*: m_tuser carries the status, m_tdata the
// returned key and the entry count after the operation.
// Insert and search launch a token that walks the cell row one cell per cycle;
// on insert into a non-full set each cell compares the carried key and swaps
// it in where it belongs, so the row stays sorted. The result appears once the
// token has left the last cell, independent of the number of keys held.
// Pop shifts the whole row down by one cell and clear drops the count; both
// give their result in the cycle after the transfer.
// One operation is in flight at a time: s_tready is high while no token walks
// and the result register is free or being taken in that cycle. A new insert
// or search is therefore taken only after the previous walk has ended; pops
// and clears run at one per cycle while the receiver takes each result.
// Reset empties the set; cell contents are never read before being written.
// A stalled receiver holds the result in the output register and blocks new
// transfers until it is taken.
module sorted_unique_key_set_core #(
    parameter int DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,  // key_in[31:0]
    input  logic [1:0]  s_tuser,  // opcode[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,  // key_out[31:0], entry_count[36:32], zero pad
    output logic [2:0]  m_tuser   // status[2:0]
);
    import susk_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    state_t              state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    lnk_t                head_reg, head_next;
    op_t                 op_reg, op_next;
    logic [KeyWidth-1:0] key_reg, key_next;
    logic                full_reg, full_next;
    logic                mval_reg, mval_next;
    status_t             mstat_reg, mstat_next;
    logic [KeyWidth-1:0] mkey_reg, mkey_next;
    logic [4:0]          mcnt_reg, mcnt_next;

    lnk_t                lnk_w [DEPTH];
    logic [KeyWidth-1:0] key_w [DEPTH];
    logic                pop_shift;
    logic                accept;
    op_t                 s_op;
    lnk_t                tail;

    assign s_op     = op_t'(s_tuser);
    assign s_tready = (state_reg == ST_IDLE) && (!mval_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign tail     = lnk_w[DEPTH-1];

    // cell row: each cell takes the token from its left neighbor
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        lnk_t                cin;
        logic [KeyWidth-1:0] nkey;
        logic                occ;

        if (i == 0) begin : g_first
            assign cin = head_reg;
        end else begin : g_rest
            assign cin = lnk_w[i-1];
        end
        if (i == DEPTH - 1) begin : g_last
            assign nkey = key_w[i];
        end else begin : g_inner
            assign nkey = key_w[i+1];
        end
        assign occ = count_reg > CW'(i);

        susk_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .lnk_in    (cin),
            .occ       (occ),
            .pop_shift (pop_shift),
            .next_key  (nkey),
            .lnk_out   (lnk_w[i]),
            .key_out   (key_w[i])
        );
    end

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        head_next    = head_reg;
        head_next.tok = 1'b0;
        op_next      = op_reg;
        key_next     = key_reg;
        full_next    = full_reg;
        mval_next    = mval_reg;
        mstat_next   = mstat_reg;
        mkey_next    = mkey_reg;
        mcnt_next    = mcnt_reg;
        pop_shift    = 1'b0;

        if (mval_reg && m_tready) begin
            mval_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    unique case (s_op) inside
                        OP_INSERT, OP_SEARCH: begin
                            // launch the token; a full set only probes for a duplicate
                            head_next.tok   = 1'b1;
                            head_next.carry = 1'b1;
                            head_next.hit   = 1'b0;
                            head_next.key   = s_tdata;
                            head_next.mode  = (s_op == OP_INSERT &&
                                               count_reg != CW'(DEPTH)) ?
                                              MODE_PLACE : MODE_PROBE;
                            op_next    = s_op;
                            key_next   = s_tdata;
                            full_next  = count_reg == CW'(DEPTH);
                            state_next = ST_WALK;
                        end
                        OP_POP: begin
                            mval_next = 1'b1;
                            if (count_reg == '0) begin
                                mstat_next = STAT_EMPTY;
                                mkey_next  = '0;
                                mcnt_next  = 5'(count_reg);
                            end else begin
                                // shift the row down by one cell
                                pop_shift  = 1'b1;
                                mstat_next = STAT_OK;
                                mkey_next  = key_w[0];
                                count_next = count_reg - 1'b1;
                                mcnt_next  = 5'(count_reg - 1'b1);
                            end
                        end
                        OP_CLEAR: begin
                            count_next = '0;
                            mval_next  = 1'b1;
                            mstat_next = STAT_OK;
                            mkey_next  = s_tdata;
                            mcnt_next  = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_WALK: begin
                // token left the last cell: report and settle the count
                if (tail.tok) begin
                    state_next = ST_IDLE;
                    mval_next  = 1'b1;
                    mkey_next  = key_reg;
                    mcnt_next  = 5'(count_reg);
                    if (op_reg == OP_INSERT) begin
                        if (tail.hit) begin
                            mstat_next = STAT_DUP;
                        end else if (full_reg) begin
                            mstat_next = STAT_FULL;
                        end else begin
                            mstat_next = STAT_OK;
                            count_next = count_reg + 1'b1;
                            mcnt_next  = 5'(count_reg + 1'b1);
                        end
                    end else begin
                        mstat_next = tail.hit ? STAT_OK : STAT_NOTFOUND;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        op_reg    <= op_next;
        key_reg   <= key_next;
        full_reg  <= full_next;
        mstat_reg <= mstat_next;
        mkey_reg  <= mkey_next;
        mcnt_reg  <= mcnt_next;
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            head_reg.tok <= 1'b0;
            mval_reg     <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            head_reg  <= head_next;
            mval_reg  <= mval_next;
        end
    end

    assign m_tvalid = mval_reg;
    assign m_tdata  = {3'b000, mcnt_reg, mkey_reg};
    assign m_tuser  = mstat_reg;

    // a token leaves the row only while a walk is in progress
    a_tail_in_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        tail.tok |-> state_reg == ST_WALK)
        else $error("token at row end outside a walk");

    // the set never holds more than DEPTH keys
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("entry count beyond depth");

    // a new result follows a pop or clear transfer or the end of a walk
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(mval_reg) |-> ($past(tail.tok) ||
            ($past(accept) && ($past(s_op) == OP_POP || $past(s_op) == OP_CLEAR))))
        else $error("result without a source");

    // no transfer is taken while a token walks the row
    a_no_accept_in_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        head_reg.tok |-> !s_tready)
        else $error("transfer accepted during a walk");

endmodule

@@ tb/sorted_unique_key_set_core_tb.sv @@
`timescale 1ns / 100ps

// Self-checking bench for the sorted unique key set core.
// A directed table runs first (empty pop, extremes, duplicate, full set,
// duplicate on a full set, clear), then a long random stream shaped in phases
// that fill, churn and drain the set. Every accepted transfer goes through a
// local model of the set, and every result transfer is compared field by field
// with the oldest expected result.
module sorted_unique_key_set_core_tb;
    import susk_pkg::*;

    localparam int SET_DEPTH   = 16;
    localparam int WALK_CYCLES = SET_DEPTH + 1;
    localparam int NUM_RANDOM  = 1425;
    localparam int LONG_HOLD   = 300;              // receiver hold-off, cycles
    localparam int DRAIN_LIMIT = 200000;
    localparam int KEY_POOL_SZ = 24;

    // One result as the checker sees it
    typedef struct packed {
        status_t     status;
        logic [31:0] key;
        logic [4:0]  count;
    } set_result_t;

    // One row of the directed table; want is used only when typed is set
    typedef struct {
        op_t         op;
        logic [31:0] key;
        bit          typed;
        set_result_t want;
    } dir_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic [2:0]  m_tuser;

    // Model copy of the set, kept sorted ascending
    logic [31:0] held_keys[$];
    set_result_t pending_results[$];
    dir_row_t    dir_rows[$];
    logic [31:0] key_pool[KEY_POOL_SZ];

    int  err_cnt;
    int  results_seen;
    int  stat_seen[5];
    int  burst_left;
    int  holds_done;
    bit  hold_req;

    sorted_unique_key_set_core #(
        .DEPTH(SET_DEPTH)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Hard stop in case the block hangs
    initial begin
        #(10_000_000);
        $display("FAIL");
        $finish;
    end

    // Apply one operation to the model set and return the result it gives.
    function automatic set_result_t set_apply(input op_t op, input logic [31:0] key);
        set_result_t res;
        int          slot;
        res.status = STAT_OK;
        res.key    = key;
        case (op)
            OP_INSERT, OP_SEARCH: begin
                // find the first slot whose key is not below the request
                slot = 0;
                while (slot < held_keys.size() && held_keys[slot] < key) slot++;
                if (slot < held_keys.size() && held_keys[slot] == key) begin
                    res.status = (op == OP_INSERT) ? STAT_DUP : STAT_OK;
                end else if (op == OP_SEARCH) begin
                    res.status = STAT_NOTFOUND;
                end else if (held_keys.size() >= SET_DEPTH) begin
                    // duplicate check above wins over full
                    res.status = STAT_FULL;
                end else begin
                    held_keys.insert(slot, key);
                end
            end
            OP_POP: begin
                if (held_keys.size() == 0) begin
                    res.status = STAT_EMPTY;
                    res.key    = '0;
                end else begin
                    res.key = held_keys.pop_front();
                end
            end
            default: begin
                held_keys.delete();
            end
        endcase
        res.count = 5'(held_keys.size());
        return res;
    endfunction

    task automatic add_row(input op_t op, input logic [31:0] key, input bit typed,
                           input status_t st, input logic [31:0] k, input int c);
        dir_row_t row;
        row.op          = op;
        row.key         = key;
        row.typed       = typed;
        row.want.status = st;
        row.want.key    = k;
        row.want.count  = 5'(c);
        dir_rows.push_back(row);
    endtask

    // Present one item and hold it until the block takes it. Insert a gap
    // first whenever the current burst has run out. Return at the edge of the
    // transfer.
    task automatic offer_item(input op_t op, input logic [31:0] key);
        if (burst_left <= 0) begin
            s_tvalid <= 1'b0;
            s_tdata  <= $urandom;
            s_tuser  <= 2'($urandom);
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            // mostly short bursts, now and then a long unbroken stretch
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200)
                                                      : $urandom_range(1, 20);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= key;
        s_tuser  <= op;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        burst_left--;
    endtask

    // Receiver: stall on a pattern that changes every so often; serve a long
    // hold-off whenever the stimulus asks for one.
    initial begin : receiver
        int mode;
        int mode_left;
        int phase;
        mode      = 0;
        mode_left = 0;
        phase     = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD - 1) @(posedge aclk);
                holds_done++;
            end else begin
                if (mode_left <= 0) begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 200);
                end
                mode_left--;
                phase++;
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= ($urandom_range(0, 1) == 1);
                    2:       m_tready <= ($urandom_range(0, 4) == 0);
                    default: m_tready <= phase[0];
                endcase
            end
        end
    end

    // Check every result transfer against the oldest expected result
    always @(posedge aclk) begin : result_check
        set_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (m_tuser < 3'd5) stat_seen[m_tuser]++;
            if (pending_results.size() == 0) begin
                $error("result with nothing expected: status %0d key %h count %0d",
                       m_tuser, m_tdata[31:0], m_tdata[36:32]);
                err_cnt++;
            end else begin
                want = pending_results.pop_front();
                if (m_tuser !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, m_tuser);
                    err_cnt++;
                end
                if (m_tdata[31:0] !== want.key) begin
                    $error("key_out: expected %h, actual %h", want.key, m_tdata[31:0]);
                    err_cnt++;
                end
                if (m_tdata[36:32] !== want.count) begin
                    $error("entry_count: expected %0d, actual %0d", want.count,
                           m_tdata[36:32]);
                    err_cnt++;
                end
                if (m_tdata[39:37] !== 3'b000) begin
                    $error("tdata pad: expected 0, actual %b", m_tdata[39:37]);
                    err_cnt++;
                end
            end
        end
    end

    initial begin : stimulus
        set_result_t res;
        op_t         op;
        logic [31:0] key;
        int          r;
        int          phase_kind;
        int          guard;
        err_cnt      = 0;
        results_seen = 0;
        holds_done   = 0;
        hold_req     = 1'b0;
        burst_left   = 0;
        foreach (stat_seen[i]) stat_seen[i] = 0;

        // Drive every input to a known value before the first edge
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= OP_INSERT;

        // Extremes first, the rest of the pool random
        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'h0000_0001;
        key_pool[2] = 32'h7FFF_FFFF;
        key_pool[3] = 32'h8000_0000;
        key_pool[4] = 32'hFFFF_FFFE;
        key_pool[5] = 32'hFFFF_FFFF;
        for (int i = 6; i < KEY_POOL_SZ; i++) key_pool[i] = $urandom;

        // Directed table: typed rows carry results readable at a glance
        add_row(OP_POP,    32'h1234_5678, 1, STAT_EMPTY,    32'h0000_0000, 0);
        add_row(OP_SEARCH, 32'h0000_0000, 1, STAT_NOTFOUND, 32'h0000_0000, 0);
        add_row(OP_INSERT, 32'hFFFF_FFFF, 1, STAT_OK,       32'hFFFF_FFFF, 1);
        add_row(OP_INSERT, 32'h0000_0000, 1, STAT_OK,       32'h0000_0000, 2);
        add_row(OP_INSERT, 32'h0000_0000, 1, STAT_DUP,      32'h0000_0000, 2);
        add_row(OP_SEARCH, 32'hFFFF_FFFF, 1, STAT_OK,       32'hFFFF_FFFF, 2);
        add_row(OP_POP,    32'hDEAD_BEEF, 1, STAT_OK,       32'h0000_0000, 1);
        // fill the remaining fifteen slots out of order
        for (int i = 14; i >= 0; i--) begin
            add_row(OP_INSERT, (32'(i) * 32'h1111_1111) ^ 32'h8000_0000, 0,
                    STAT_OK, '0, 0);
        end
        add_row(OP_INSERT, 32'h1234_5678, 1, STAT_FULL,     32'h1234_5678, 16);
        add_row(OP_INSERT, 32'hFFFF_FFFF, 1, STAT_DUP,      32'hFFFF_FFFF, 16);
        add_row(OP_SEARCH, 32'h6EEE_EEEE, 0, STAT_OK,       '0, 0);
        add_row(OP_CLEAR,  32'h5A5A_5A5A, 1, STAT_OK,       32'h5A5A_5A5A, 0);
        add_row(OP_POP,    32'hA5A5_A5A5, 1, STAT_EMPTY,    32'h0000_0000, 0);

        // Reset once, then release
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i]) begin
            offer_item(dir_rows[i].op, dir_rows[i].key);
            // always advance the model; typed rows override its answer
            res = set_apply(dir_rows[i].op, dir_rows[i].key);
            pending_results.push_back(dir_rows[i].typed ? dir_rows[i].want : res);
        end

        // Random part in phases: fill, churn, drain
        phase_kind = 0;
        for (int n = 0; n < NUM_RANDOM; n++) begin
            if (n % 100 == 0) phase_kind = $urandom_range(0, 2);
            r = $urandom_range(0, 99);
            case (phase_kind)
                0:       op = (r < 70) ? OP_INSERT : (r < 90) ? OP_SEARCH
                            : (r < 98) ? OP_POP : OP_CLEAR;
                1:       op = (r < 40) ? OP_INSERT : (r < 70) ? OP_SEARCH
                            : (r < 98) ? OP_POP : OP_CLEAR;
                default: op = (r < 15) ? OP_INSERT : (r < 40) ? OP_SEARCH
                            : (r < 98) ? OP_POP : OP_CLEAR;
            endcase
            // draw keys that are held, from the pool, or anywhere
            r = $urandom_range(0, 99);
            if (op != OP_POP && op != OP_CLEAR && held_keys.size() != 0 && r < 30)
                key = held_keys[$urandom_range(0, held_keys.size() - 1)];
            else if (r < 65)
                key = key_pool[$urandom_range(0, KEY_POOL_SZ - 1)];
            else
                key = $urandom;

            // Long receiver hold-off while the sender keeps offering
            if (n == 300 || n == 1100) hold_req = 1'b1;

            offer_item(op, key);
            pending_results.push_back(set_apply(op, key));

            // Pause the sender until every expected result is back
            if (n == 700) begin
                s_tvalid <= 1'b0;
                while (pending_results.size() != 0) @(posedge aclk);
                repeat (WALK_CYCLES) @(posedge aclk);
            end
        end

        // Drain and let the block settle
        s_tvalid <= 1'b0;
        guard = 0;
        while (pending_results.size() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge aclk);
            guard++;
        end
        if (pending_results.size() != 0) begin
            $error("%0d results never arrived", pending_results.size());
            err_cnt++;
        end
        repeat (4 * WALK_CYCLES) @(posedge aclk);

        $display("Checked %0d results over %0d directed and %0d random transfers.",
                 results_seen, dir_rows.size(), NUM_RANDOM);
        $display("Status mix ok/dup/full/notfound/empty: %0d/%0d/%0d/%0d/%0d, holds %0d",
                 stat_seen[0], stat_seen[1], stat_seen[2], stat_seen[3], stat_seen[4],
                 holds_done);
        if (err_cnt == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
